### rtl/ddss_pkg.sv
`timescale 1ns / 1ps

package ddss_pkg;

  // Field widths fixed by the interface
  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned LINE_W   = 3;
  localparam int unsigned SEG_W    = 7;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_LINES_DEF       = 6;
  localparam int unsigned MAX_LOAD_DIGITS_DEF = 5;

  // Request operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_WRITE
  } state_e;

  // Seven-segment code for one decimal digit; non-decimal codes blank
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 7'h77;
      4'd1:    code = 7'h24;
      4'd2:    code = 7'h5D;
      4'd3:    code = 7'h6D;
      4'd4:    code = 7'h2E;
      4'd5:    code = 7'h6B;
      4'd6:    code = 7'h7B;
      4'd7:    code = 7'h25;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

### rtl/decimal_seven_segment_scan.sv
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// in       in_valid_i / in_stall_o operation_i, number_value_i, digit_count_i, scan_line_i
// out      out_valid_o/ out_stall_i segment_pattern_o, digit_drive_n_o
//
// A scan request goes straight into the output register.
// A load request runs the binary-to-decimal shift register one input bit per
// cycle for all NUMBER_W = 32 bits, then writes one store entry per cycle for
// each digit of the count; a count of zero writes no entry.
// Reset clears the digit store to blank and empties the output register.
// The input stalls during a load and while a held result is stalled.

module decimal_seven_segment_scan #(
  parameter int unsigned NUM_LINES       = ddss_pkg::NUM_LINES_DEF,
  parameter int unsigned MAX_LOAD_DIGITS = ddss_pkg::MAX_LOAD_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [ddss_pkg::NUMBER_W-1:0] number_value_i,
  input  logic [ddss_pkg::COUNT_W-1:0]  digit_count_i,
  input  logic [ddss_pkg::LINE_W-1:0]   scan_line_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ddss_pkg::SEG_W-1:0]    segment_pattern_o,
  output logic [NUM_LINES-1:0]          digit_drive_n_o
);

  localparam int unsigned BCD_W   = MAX_LOAD_DIGITS * 4;
  localparam int unsigned CNT_W   = $clog2(MAX_LOAD_DIGITS + 1);
  localparam int unsigned BIT_W   = $clog2(ddss_pkg::NUMBER_W);
  localparam int unsigned IDX_W   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(ddss_pkg::NUMBER_W - 1);

  ddss_pkg::state_e state_q, state_d;

  logic [ddss_pkg::SEG_W-1:0]    store_q [NUM_LINES];
  logic [ddss_pkg::NUMBER_W-1:0] shift_q;
  logic [BCD_W-1:0]              bcd_q;
  logic [BCD_W-1:0]              bcd_step;
  logic [BIT_W-1:0]              bit_q;
  logic [CNT_W-1:0]              pos_q;
  logic [CNT_W-1:0]              count_clamped;
  logic                          in_accept;
  logic                          line_hit;
  logic [ddss_pkg::SEG_W-1:0]    seg_read;
  logic [NUM_LINES-1:0]          drive_read;

  assign in_stall_o = (state_q != ddss_pkg::ST_IDLE) || (out_valid_o && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Clamp the requested digit count
  always_comb begin
    if (32'(digit_count_i) > MAX_LOAD_DIGITS) begin
      count_clamped = CNT_W'(MAX_LOAD_DIGITS);
    end else begin
      count_clamped = CNT_W'(digit_count_i);
    end
  end

  // One double-dabble step: adjust each digit, then shift in the next bit
  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = bcd_q;
    for (int i = 0; i < int'(MAX_LOAD_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
    bcd_step = {adj[BCD_W-2:0], shift_q[ddss_pkg::NUMBER_W-1]};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ddss_pkg::ST_IDLE: begin
        if (in_accept && operation_i == ddss_pkg::OP_LOAD && count_clamped != '0) begin
          state_d = ddss_pkg::ST_CONVERT;
        end
      end
      ddss_pkg::ST_CONVERT: begin
        if (bit_q == LAST_BIT) begin
          state_d = ddss_pkg::ST_WRITE;
        end
      end
      ddss_pkg::ST_WRITE: begin
        if (pos_q == '0) begin
          state_d = ddss_pkg::ST_IDLE;
        end
      end
      default: state_d = ddss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Conversion datapath: latch the number, shift a bit per cycle, then
  // drain the digits least significant first
  always_ff @(posedge clk_i) begin
    case (state_q)
      ddss_pkg::ST_IDLE: begin
        shift_q <= number_value_i;
        bcd_q   <= '0;
        bit_q   <= '0;
        pos_q   <= count_clamped - CNT_W'(1);
      end
      ddss_pkg::ST_CONVERT: begin
        shift_q <= {shift_q[ddss_pkg::NUMBER_W-2:0], 1'b0};
        bcd_q   <= bcd_step;
        bit_q   <= bit_q + BIT_W'(1);
      end
      ddss_pkg::ST_WRITE: begin
        bcd_q <= bcd_q >> 4;
        pos_q <= pos_q - CNT_W'(1);
      end
      default: begin
        bcd_q <= bcd_q;
      end
    endcase
  end

  // Digit store: write one entry per cycle, drop entries beyond the display
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_LINES); i++) begin
        store_q[i] <= '0;
      end
    end else if (state_q == ddss_pkg::ST_WRITE && 32'(pos_q) < NUM_LINES) begin
      store_q[IDX_W'(pos_q)] <= ddss_pkg::seg_code(bcd_q[3:0]);
    end
  end

  // Scan read: at most one line low, segments from the selected entry
  always_comb begin
    line_hit = 32'(scan_line_i) < NUM_LINES;
    seg_read = line_hit ? store_q[IDX_W'(scan_line_i)] : '0;
    for (int j = 0; j < int'(NUM_LINES); j++) begin
      drive_read[j] = !(line_hit && scan_line_i == ddss_pkg::LINE_W'(j));
    end
  end

  // Output register: fill on a scan request, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_accept && operation_i == ddss_pkg::OP_SCAN) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && operation_i == ddss_pkg::OP_SCAN) begin
      segment_pattern_o <= seg_read;
      digit_drive_n_o   <= drive_read;
    end
  end

endmodule

### rtl/ddss_checker.sv
`timescale 1ns / 1ps

module ddss_checker #(
  parameter int unsigned NUM_LINES = ddss_pkg::NUM_LINES_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          operation_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ddss_pkg::SEG_W-1:0]    segment_pattern_o,
  input logic [NUM_LINES-1:0]          digit_drive_n_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segment_pattern_o)
      && $stable(digit_drive_n_o))
    else $error("stalled result changed");

  // At most one digit common driven low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(~digit_drive_n_o))
    else $error("more than one digit common low");

  // No line selected means blank segments
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (&digit_drive_n_o) |-> segment_pattern_o == '0)
    else $error("segments lit with no line selected");

  // An accepted scan request gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == ddss_pkg::OP_SCAN |=> out_valid_o)
    else $error("scan request produced no result");

endmodule

bind decimal_seven_segment_scan ddss_checker #(.NUM_LINES(NUM_LINES)) u_ddss_checker (.*);
